// ----- rtl/utl_pkg.sv -----
`timescale 1ns / 1ps
package utl_pkg;

   localparam int PARAM_COUNT = 14;
   localparam int FRAME_LEN   = 4 * PARAM_COUNT;
   localparam int PTR_W       = 6;
   localparam int STEP_W      = 4;

   localparam logic [7:0] SYNC_A     = 8'h55;
   localparam logic [7:0] SYNC_B     = 8'hAA;
   localparam logic [7:0] FRAME_END  = 8'hAB;
   localparam logic [7:0] TRAILER    = 8'h0B;
   localparam logic [7:0] CMD_TOG_A  = 8'h30;
   localparam logic [7:0] CMD_TOG_B  = 8'h31;
   localparam logic [7:0] CMD_PEND   = 8'h32;
   localparam logic [7:0] CMD_RECV   = 8'h33;

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_SEND    = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_IDLE  = 4'd0;
   localparam step_type ST_RXB   = 4'd1;
   localparam step_type ST_STAT  = 4'd2;
   localparam step_type ST_SND0  = 4'd3;
   localparam step_type ST_HDR_A = 4'd4;
   localparam step_type ST_HDR_B = 4'd5;
   localparam step_type ST_HDR_C = 4'd6;
   localparam step_type ST_COUNT = 4'd7;
   localparam step_type ST_BODY  = 4'd8;
   localparam step_type ST_TRAIL = 4'd9;
   localparam step_type ST_RD0   = 4'd10;
   localparam step_type ST_GATH  = 4'd11;

   typedef enum logic [1:0] {
      SRC_STAT,
      SRC_CONST,
      SRC_MEM
   } src_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GO,
      JMP_OP,
      JMP_UNTIL_FRAME,
      JMP_UNTIL_WORD
   } jmp_type;

   typedef struct packed {
      logic     accept;
      logic     rx_apply;
      logic     clr_pend;
      logic     emit;
      logic     kind;
      logic     last;
      src_type  src;
      logic [7:0] konst;
      logic     advance;
      logic     gather;
      jmp_type  jmp;
      step_type target;
   } cw_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] op;
      logic       emit_ok;
      logic       frame_done;
      logic       word_done;
   } sts_type;

   function automatic cw_type ucode(input step_type step);
      cw_type cw;
      cw = '{accept: 1'b0, rx_apply: 1'b0, clr_pend: 1'b0, emit: 1'b0, kind: 1'b0,
             last: 1'b0, src: SRC_STAT, konst: 8'h00, advance: 1'b0, gather: 1'b0,
             jmp: JMP_NEXT, target: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            cw.accept = 1'b1;
            cw.jmp    = JMP_OP;
         end
         ST_RXB: begin
            cw.rx_apply = 1'b1;
         end
         ST_STAT: begin
            cw.emit   = 1'b1;
            cw.last   = 1'b1;
            cw.jmp    = JMP_GO;
            cw.target = ST_IDLE;
         end
         ST_SND0: begin
            cw.clr_pend = 1'b1;
         end
         ST_HDR_A: begin
            cw.emit = 1'b1; cw.kind = 1'b1; cw.src = SRC_CONST; cw.konst = SYNC_A;
         end
         ST_HDR_B: begin
            cw.emit = 1'b1; cw.kind = 1'b1; cw.src = SRC_CONST; cw.konst = SYNC_B;
         end
         ST_HDR_C: begin
            cw.emit = 1'b1; cw.kind = 1'b1; cw.src = SRC_CONST; cw.konst = FRAME_END;
         end
         ST_COUNT: begin
            cw.emit  = 1'b1; cw.kind = 1'b1; cw.src = SRC_CONST;
            cw.konst = 8'(PARAM_COUNT);
         end
         ST_BODY: begin
            cw.emit    = 1'b1; cw.kind = 1'b1; cw.src = SRC_MEM;
            cw.advance = 1'b1;
            cw.jmp     = JMP_UNTIL_FRAME;
            cw.target  = ST_TRAIL;
         end
         ST_TRAIL: begin
            cw.emit  = 1'b1; cw.kind = 1'b1; cw.last = 1'b1; cw.src = SRC_CONST;
            cw.konst = TRAILER;
            cw.jmp   = JMP_GO;
            cw.target = ST_IDLE;
         end
         ST_RD0: begin
            // wait for the first byte of the word to leave the memory
         end
         ST_GATH: begin
            cw.gather  = 1'b1;
            cw.advance = 1'b1;
            cw.jmp     = JMP_UNTIL_WORD;
            cw.target  = ST_STAT;
         end
         default: begin
            cw.jmp    = JMP_GO;
            cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ----- rtl/utl_seq.sv -----
`timescale 1ns / 1ps
module utl_seq (
   input  logic              clock,
   input  logic              reset,
   input  utl_pkg::sts_type  sts,
   output utl_pkg::cw_type   cw,
   output logic              step_go
);

   utl_pkg::step_type upc_ff;
   utl_pkg::step_type upc_in;

   assign cw = utl_pkg::ucode(upc_ff);

   // a step holds while its emit finds the output full or its accept sees no item
   assign step_go = !(cw.emit && !sts.emit_ok) && !(cw.accept && !sts.req_valid);

   always_comb begin
      upc_in = upc_ff;
      if (step_go) begin
         unique case (cw.jmp)
            utl_pkg::JMP_NEXT: upc_in = upc_ff + 1'b1;
            utl_pkg::JMP_GO:   upc_in = cw.target;
            utl_pkg::JMP_OP: begin
               unique case (utl_pkg::op_type'(sts.op))
                  utl_pkg::OP_RX_BYTE: upc_in = utl_pkg::ST_RXB;
                  utl_pkg::OP_SEND:    upc_in = utl_pkg::ST_SND0;
                  utl_pkg::OP_READ:    upc_in = utl_pkg::ST_RD0;
                  default:             upc_in = utl_pkg::ST_STAT;
               endcase
            end
            utl_pkg::JMP_UNTIL_FRAME: upc_in = sts.frame_done ? cw.target : upc_ff;
            utl_pkg::JMP_UNTIL_WORD:  upc_in = sts.word_done ? cw.target : upc_ff;
            default:                  upc_in = utl_pkg::ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= utl_pkg::ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- rtl/utl_dp.sv -----
`timescale 1ns / 1ps
module utl_dp (
   input  logic              clock,
   input  logic              reset,
   input  utl_pkg::cw_type   cw,
   input  logic              step_go,
   output utl_pkg::sts_type  sts,
   input  logic              req_valid,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_rx_byte,
   input  logic [3:0]        req_word_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last,
   output logic              rsp_stream_enable,
   output logic              rsp_param_pending,
   output logic              rsp_beep_flag,
   output logic              rsp_committed,
   output logic              rsp_frame_dropped,
   output logic [31:0]       rsp_param_value
);

   localparam int PTR_W = utl_pkg::PTR_W;

   // two banks: frames land in the idle bank, a commit swaps banks
   logic [7:0] mem [0:(2**(PTR_W+1))-1];

   logic             recv_ff, recv_in;
   logic [PTR_W-1:0] cnt_ff, cnt_in;
   logic             tog_ff, tog_in;
   logic             pend_ff, pend_in;
   logic             beep_ff, beep_in;
   logic             bank_ff, bank_in;
   logic             bvalid_ff, bvalid_in;

   logic [7:0]       rxb_ff, rxb_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [31:0]      val_ff, val_in;
   logic             comm_ff, comm_in;
   logic             drop_ff, drop_in;
   logic             rdok_ff, rdok_in;
   logic [7:0]       rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             kind_ff, kind_in;
   logic [7:0]       txb_ff, txb_in;
   logic             last_ff, last_in;
   logic             o_tog_ff, o_tog_in;
   logic             o_pend_ff, o_pend_in;
   logic             o_beep_ff, o_beep_in;
   logic             o_comm_ff, o_comm_in;
   logic             o_drop_ff, o_drop_in;
   logic [31:0]      o_val_ff, o_val_in;

   logic             emit_ok;
   logic             adv;
   logic [PTR_W-1:0] ptr_next;
   logic [PTR_W:0]   rd_addr;
   logic [PTR_W:0]   wr_addr;
   logic             wr_en;
   logic [7:0]       body_byte;
   logic [7:0]       gath_byte;

   assign emit_ok   = !rsp_valid_ff || rsp_ready;
   assign adv       = cw.advance && step_go;
   assign ptr_next  = ptr_ff + 1'b1;
   assign rd_addr   = {bank_ff, adv ? ptr_next : ptr_ff};
   assign wr_addr   = {~bank_ff, cnt_ff};
   assign body_byte = bvalid_ff ? rd_ff : 8'h00;
   assign gath_byte = rdok_ff ? rd_ff : 8'h00;

   assign sts.req_valid  = req_valid;
   assign sts.op         = req_op;
   assign sts.emit_ok    = emit_ok;
   assign sts.frame_done = (ptr_ff == PTR_W'(utl_pkg::FRAME_LEN - 1));
   assign sts.word_done  = (ptr_ff[1:0] == 2'b11);

   always_comb begin
      recv_in   = recv_ff;
      cnt_in    = cnt_ff;
      tog_in    = tog_ff;
      pend_in   = pend_ff;
      beep_in   = beep_ff;
      bank_in   = bank_ff;
      bvalid_in = bvalid_ff;
      rxb_in    = rxb_ff;
      ptr_in    = ptr_ff;
      val_in    = val_ff;
      comm_in   = comm_ff;
      drop_in   = drop_ff;
      rdok_in   = rdok_ff;
      wr_en     = 1'b0;

      if (cw.accept && req_valid) begin
         rxb_in  = req_rx_byte;
         ptr_in  = (req_op == utl_pkg::OP_READ) ? {req_word_index, 2'b00} : '0;
         val_in  = '0;
         comm_in = 1'b0;
         drop_in = 1'b0;
         rdok_in = bvalid_ff && (req_word_index < 4'(utl_pkg::PARAM_COUNT));
      end

      if (cw.rx_apply) begin
         if (recv_ff) begin
            if (cnt_ff != PTR_W'(utl_pkg::FRAME_LEN)) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               cnt_in  = '0;
               recv_in = 1'b0;
               if (rxb_ff == utl_pkg::FRAME_END) begin
                  bank_in   = ~bank_ff;
                  bvalid_in = 1'b1;
                  pend_in   = 1'b1;
                  comm_in   = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
         end else begin
            beep_in = 1'b1;
            case (rxb_ff) inside
               utl_pkg::CMD_TOG_A, utl_pkg::CMD_TOG_B: tog_in = ~tog_ff;
               utl_pkg::CMD_PEND: pend_in = 1'b1;
               utl_pkg::CMD_RECV: begin
                  recv_in = 1'b1;
                  cnt_in  = '0;
               end
               default: ;
            endcase
         end
      end

      if (cw.clr_pend) begin
         pend_in = 1'b0;
      end
      if (adv) begin
         ptr_in = ptr_next;
      end
      if (cw.gather) begin
         val_in = {gath_byte, val_ff[31:8]};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      txb_in       = txb_ff;
      last_in      = last_ff;
      o_tog_in     = o_tog_ff;
      o_pend_in    = o_pend_ff;
      o_beep_in    = o_beep_ff;
      o_comm_in    = o_comm_ff;
      o_drop_in    = o_drop_ff;
      o_val_in     = o_val_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cw.emit && emit_ok) begin
         rsp_valid_in = 1'b1;
         kind_in      = cw.kind;
         last_in      = cw.last;
         o_tog_in     = tog_ff;
         o_pend_in    = pend_ff;
         o_beep_in    = beep_ff;
         o_comm_in    = 1'b0;
         o_drop_in    = 1'b0;
         o_val_in     = '0;
         case (cw.src)
            utl_pkg::SRC_CONST: txb_in = cw.konst;
            utl_pkg::SRC_MEM:   txb_in = body_byte;
            default: begin
               txb_in    = 8'h00;
               o_comm_in = comm_ff;
               o_drop_in = drop_ff;
               o_val_in  = val_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= rxb_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff      <= 1'b0;
         cnt_ff       <= '0;
         tog_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         beep_ff      <= 1'b0;
         bank_ff      <= 1'b0;
         bvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         recv_ff      <= recv_in;
         cnt_ff       <= cnt_in;
         tog_ff       <= tog_in;
         pend_ff      <= pend_in;
         beep_ff      <= beep_in;
         bank_ff      <= bank_in;
         bvalid_ff    <= bvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rxb_ff    <= rxb_in;
      ptr_ff    <= ptr_in;
      val_ff    <= val_in;
      comm_ff   <= comm_in;
      drop_ff   <= drop_in;
      rdok_ff   <= rdok_in;
      kind_ff   <= kind_in;
      txb_ff    <= txb_in;
      last_ff   <= last_in;
      o_tog_ff  <= o_tog_in;
      o_pend_ff <= o_pend_in;
      o_beep_ff <= o_beep_in;
      o_comm_ff <= o_comm_in;
      o_drop_ff <= o_drop_in;
      o_val_ff  <= o_val_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_tx_byte       = txb_ff;
   assign rsp_last          = last_ff;
   assign rsp_stream_enable = o_tog_ff;
   assign rsp_param_pending = o_pend_ff;
   assign rsp_beep_flag     = o_beep_ff;
   assign rsp_committed     = o_comm_ff;
   assign rsp_frame_dropped = o_drop_ff;
   assign rsp_param_value   = o_val_ff;

endmodule

// ----- rtl/uart_param_tuning_link_top.sv -----
`timescale 1ns / 1ps
// Host tuning link over a UART byte stream.
// req channel: one item per received byte (op 0), send-frame request (op 1)
// or parameter word read (op 2). rsp channel: result items; rsp_last marks
// the final result of an item. A byte or read gives one status item, a send
// gives 61 frame bytes: 55 AA AB, count, 56 parameter bytes, 0B.
// A byte op applies the byte, then returns status; an undefined op returns
// status directly; a read gathers the four bytes of the word from the
// memory, then returns status; a send emits one frame byte per cycle while
// rsp_ready allows. Each item is finished before the next is taken.
// Rate is set by the single microprogram counter, which runs one step per
// cycle while no step holds, and by the one read port of the frame memory
// (one byte per cycle). req_ready is high only out of reset while the
// sequencer sits at its dispatch step.
// A stalled rsp_ready freezes the sequencer at its emit step; nothing is lost.
// Reset (synchronous) clears flags, receive mode and the output valid bit;
// parameter words read as zero until the first frame commits.
module uart_param_tuning_link_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic [3:0]  req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_stream_enable,
   output logic        rsp_param_pending,
   output logic        rsp_beep_flag,
   output logic        rsp_committed,
   output logic        rsp_frame_dropped,
   output logic [31:0] rsp_param_value
);

   utl_pkg::cw_type  cw;
   utl_pkg::sts_type sts;
   logic             step_go;

   assign req_ready = cw.accept && !reset;

   utl_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .sts     (sts),
      .cw      (cw),
      .step_go (step_go)
   );

   utl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cw                (cw),
      .step_go           (step_go),
      .sts               (sts),
      .req_valid         (req_valid),
      .req_op            (req_op),
      .req_rx_byte       (req_rx_byte),
      .req_word_index    (req_word_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .rsp_stream_enable (rsp_stream_enable),
      .rsp_param_pending (rsp_param_pending),
      .rsp_beep_flag     (rsp_beep_flag),
      .rsp_committed     (rsp_committed),
      .rsp_frame_dropped (rsp_frame_dropped),
      .rsp_param_value   (rsp_param_value)
   );

endmodule
